// ===== hw/rtl/byte_range_chunk_splitter_unit_macros.svh =====
// Assertion macros shared by the checker of the chunk splitter.
`ifndef BYTE_RANGE_CHUNK_SPLITTER_UNIT_MACROS_SVH
`define BYTE_RANGE_CHUNK_SPLITTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BRCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BRCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/brcs_pkg.sv =====
// Shared widths, constants and types of the byte range chunk splitter.
`default_nettype none
package brcs_pkg;

  localparam int unsigned StartW   = 52;
  localparam int unsigned CountW   = 18;
  localparam int unsigned IdxW     = 32;
  localparam int unsigned OffW     = 20;
  localparam int unsigned LenW     = 18;
  localparam int unsigned BufW     = 17;
  localparam int unsigned CsW      = 21;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  localparam int unsigned MinChunk = 4096;
  localparam int unsigned MaxChunk = 1048576;
  // Largest quotient is the widest start byte over the smallest chunk.
  localparam int unsigned QuotW    = StartW - $clog2(MinChunk);
  localparam int unsigned DivCntW  = $clog2(StartW + 1);

  localparam int unsigned MaxRequestBytesDef = 131072;
  localparam int unsigned MaxResults = 33;
  localparam int unsigned NumW       = $clog2(MaxResults);

  localparam logic [CfgIdxW-1:0] CfgChunkSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgChunkCount = 1'b1;

  typedef struct packed {
    logic              start;
    logic [StartW-1:0] dividend;
    logic [CsW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
    logic [OffW-1:0]  rem;
  } div_res_t;

  typedef struct packed {
    logic [StartW-1:0] start_byte;
    logic [CountW-1:0] count;
    logic [CsW-1:0]    chunk_size;
  } req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brcs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module brcs_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire brcs_pkg::div_req_t  req_i,
  output brcs_pkg::div_res_t       res_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [brcs_pkg::DivCntW-1:0]        cnt_q, cnt_d;
  logic [brcs_pkg::StartW-1:0]         quo_q, quo_d;
  logic [brcs_pkg::OffW-1:0]           rem_q, rem_d;
  logic [brcs_pkg::CsW-1:0]            dvs_q, dvs_d;
  logic [brcs_pkg::CsW-1:0]            trial;
  logic [brcs_pkg::CsW-1:0]            diff;
  logic                                fits;

  // The partial remainder stays below the divisor, so it fits in OffW bits.
  assign trial = {rem_q, quo_q[brcs_pkg::StartW-1]};
  assign fits  = trial >= dvs_q;
  assign diff  = trial - dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = brcs_pkg::DivCntW'(brcs_pkg::StartW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[brcs_pkg::StartW-2:0], fits};
      rem_d = fits ? diff[brcs_pkg::OffW-1:0] : trial[brcs_pkg::OffW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == brcs_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q[brcs_pkg::QuotW-1:0];
  assign res_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== hw/rtl/brcs_seq.sv =====
// Request sequencer: divides, then walks chunks a segment a cycle unless stalled.
`default_nettype none
module brcs_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire brcs_pkg::req_t                req_i,
  input  wire logic [brcs_pkg::IdxW-1:0]     chunk_count_i,
  output brcs_pkg::div_req_t                 div_req_o,
  input  wire brcs_pkg::div_res_t            div_res_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [brcs_pkg::IdxW-1:0]          chunk_index_o,
  output logic [brcs_pkg::OffW-1:0]          chunk_offset_o,
  output logic [brcs_pkg::LenW-1:0]          segment_length_o,
  output logic [brcs_pkg::BufW-1:0]          buffer_offset_o,
  output logic                               partial_chunk_o,
  output logic                               stopped_at_disk_end_o,
  output logic                               last_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [brcs_pkg::CsW-1:0]        cs_q, cs_d;
  logic [brcs_pkg::CountW-1:0]     cnt_q, cnt_d;
  logic [brcs_pkg::CountW-1:0]     pos_q, pos_d;
  logic [brcs_pkg::OffW-1:0]       off_q, off_d;
  logic [brcs_pkg::QuotW-1:0]      idx_q, idx_d;
  logic [brcs_pkg::NumW-1:0]       num_q, num_d;

  logic                            out_valid_q, out_valid_d;
  logic [brcs_pkg::IdxW-1:0]       idx_out_q;
  logic [brcs_pkg::OffW-1:0]       off_out_q;
  logic [brcs_pkg::LenW-1:0]       len_out_q;
  logic [brcs_pkg::BufW-1:0]       buf_out_q;
  logic                            part_out_q, stop_out_q, last_out_q;

  logic                            accept;
  logic                            out_free;
  logic                            load;
  logic [brcs_pkg::CsW-1:0]        len_full;
  logic [brcs_pkg::CountW-1:0]     rest;
  logic                            rest_fits;
  logic [brcs_pkg::LenW-1:0]       seg_len;
  logic                            seg_partial;
  logic [brcs_pkg::QuotW:0]        idx_nxt;
  logic                            beyond_nxt;
  logic                            cap;
  logic                            seg_last;
  logic                            seg_stop;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == StEmit) && out_free;

  assign div_req_o.start    = accept && (req_i.count != '0);
  assign div_req_o.dividend = req_i.start_byte;
  assign div_req_o.divisor  = req_i.chunk_size;

  // Segment arithmetic for the chunk at idx_q.
  assign len_full    = cs_q - brcs_pkg::CsW'(off_q);
  assign rest        = cnt_q - pos_q;
  assign rest_fits   = brcs_pkg::CsW'(rest) <= len_full;
  assign seg_len     = rest_fits ? rest : len_full[brcs_pkg::LenW-1:0];
  assign seg_partial = brcs_pkg::CsW'(seg_len) < cs_q;
  assign idx_nxt     = (brcs_pkg::QuotW+1)'(idx_q) + 1'b1;
  assign beyond_nxt  = idx_nxt >= (brcs_pkg::QuotW+1)'(chunk_count_i);
  assign cap         = num_q == brcs_pkg::NumW'(brcs_pkg::MaxResults - 1);
  assign seg_last    = rest_fits || beyond_nxt || cap;
  // The result cap ends the request without the disk-end flag.
  assign seg_stop    = !rest_fits && !cap && beyond_nxt;

  always_comb begin
    state_d = state_q;
    cs_d    = cs_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    off_d   = off_q;
    idx_d   = idx_q;
    num_d   = num_q;
    case (state_q)
      StIdle: begin
        if (accept && (req_i.count != '0)) begin
          cs_d    = req_i.chunk_size;
          cnt_d   = req_i.count;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_res_i.done) begin
          idx_d = div_res_i.quot;
          off_d = div_res_i.rem;
          pos_d = '0;
          num_d = '0;
          if (div_res_i.quot >= brcs_pkg::QuotW'(chunk_count_i)) begin
            state_d = StIdle;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          pos_d = pos_q + seg_len;
          off_d = '0;
          idx_d = idx_nxt[brcs_pkg::QuotW-1:0];
          num_d = num_q + 1'b1;
          if (seg_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q  <= cs_d;
    cnt_q <= cnt_d;
    pos_q <= pos_d;
    off_q <= off_d;
    idx_q <= idx_d;
    num_q <= num_d;
    if (load) begin
      idx_out_q  <= idx_q[brcs_pkg::IdxW-1:0];
      off_out_q  <= off_q;
      len_out_q  <= seg_len;
      buf_out_q  <= pos_q[brcs_pkg::BufW-1:0];
      part_out_q <= seg_partial;
      stop_out_q <= seg_stop;
      last_out_q <= seg_last;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign chunk_index_o         = idx_out_q;
  assign chunk_offset_o        = off_out_q;
  assign segment_length_o      = len_out_q;
  assign buffer_offset_o       = buf_out_q;
  assign partial_chunk_o       = part_out_q;
  assign stopped_at_disk_end_o = stop_out_q;
  assign last_o                = last_out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/byte_range_chunk_splitter_unit.sv =====
// Top level of the byte range chunk splitter: configuration registers and request front end.
// Splits one disk request (start byte, byte count) into one segment beat per chunk it
// touches, at most 33 beats and none past the disk end. A request is taken only while
// the unit is idle; it then passes through a bit-serial divider (start byte over chunk
// size, one quotient bit per cycle), after which segments leave at one beat per cycle
// while the output is not stalled. The next request may be accepted while the final
// segment beat still waits on the output. A zero byte count finishes in the accepting
// cycle; a start beyond the disk yields no beats after the divide.
// Configuration registers: index 0 is the chunk size (clamped to 4096..1048576 when used),
// index 1 the number of chunks on the disk; write them only while the unit is idle.
`default_nettype none
module byte_range_chunk_splitter_unit #(
  parameter int unsigned MaxRequestBytes = brcs_pkg::MaxRequestBytesDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [brcs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [brcs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [brcs_pkg::StartW-1:0]       start_byte_i,
  input  wire logic [brcs_pkg::CountW-1:0]       byte_count_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [brcs_pkg::IdxW-1:0]              chunk_index_o,
  output logic [brcs_pkg::OffW-1:0]              chunk_offset_o,
  output logic [brcs_pkg::LenW-1:0]              segment_length_o,
  output logic [brcs_pkg::BufW-1:0]              buffer_offset_o,
  output logic                                   partial_chunk_o,
  output logic                                   stopped_at_disk_end_o,
  output logic                                   last_o
);

  logic [brcs_pkg::CsW-1:0]     chunk_size_q, chunk_size_d;
  logic [brcs_pkg::IdxW-1:0]    chunk_count_q, chunk_count_d;
  logic [brcs_pkg::CsW-1:0]     cs_use;
  logic [brcs_pkg::CountW-1:0]  count_sat;
  brcs_pkg::req_t               req;
  brcs_pkg::div_req_t           div_req;
  brcs_pkg::div_res_t           div_res;

  always_comb begin
    chunk_size_d  = chunk_size_q;
    chunk_count_d = chunk_count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        brcs_pkg::CfgChunkSize:  chunk_size_d  = cfg_wdata_i[brcs_pkg::CsW-1:0];
        brcs_pkg::CfgChunkCount: chunk_count_d = cfg_wdata_i[brcs_pkg::IdxW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q  <= brcs_pkg::CsW'(131072);
      chunk_count_q <= '0;
    end else begin
      chunk_size_q  <= chunk_size_d;
      chunk_count_q <= chunk_count_d;
    end
  end

  always_comb begin
    if (chunk_size_q < brcs_pkg::CsW'(brcs_pkg::MinChunk)) begin
      cs_use = brcs_pkg::CsW'(brcs_pkg::MinChunk);
    end else if (chunk_size_q > brcs_pkg::CsW'(brcs_pkg::MaxChunk)) begin
      cs_use = brcs_pkg::CsW'(brcs_pkg::MaxChunk);
    end else begin
      cs_use = chunk_size_q;
    end
  end

  // Oversized requests are cut to the largest request size.
  assign count_sat = (32'(byte_count_i) > 32'(MaxRequestBytes)) ?
                     brcs_pkg::CountW'(MaxRequestBytes) : byte_count_i;

  assign req.start_byte = start_byte_i;
  assign req.count      = count_sat;
  assign req.chunk_size = cs_use;

  brcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  brcs_seq u_seq (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .req_i                 (req),
    .chunk_count_i         (chunk_count_q),
    .div_req_o             (div_req),
    .div_res_i             (div_res),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .chunk_index_o         (chunk_index_o),
    .chunk_offset_o        (chunk_offset_o),
    .segment_length_o      (segment_length_o),
    .buffer_offset_o       (buffer_offset_o),
    .partial_chunk_o       (partial_chunk_o),
    .stopped_at_disk_end_o (stopped_at_disk_end_o),
    .last_o                (last_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/brcs_chk.sv =====
// Port-level checker of the chunk splitter and its bind to the top level.
`default_nettype none
`include "byte_range_chunk_splitter_unit_macros.svh"
module brcs_chk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire logic [brcs_pkg::CountW-1:0]   byte_count_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire logic [brcs_pkg::IdxW-1:0]     chunk_index_o,
  input  wire logic [brcs_pkg::OffW-1:0]     chunk_offset_o,
  input  wire logic [brcs_pkg::LenW-1:0]     segment_length_o,
  input  wire logic                          partial_chunk_o,
  input  wire logic                          stopped_at_disk_end_o,
  input  wire logic                          last_o
);

  // A non-empty request keeps the unit busy for at least the divide.
  `BRCS_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o && (byte_count_i != '0), in_stall_o, "request accepted but unit not busy")

  `BRCS_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(chunk_index_o) && $stable(segment_length_o), "stalled segment beat changed")

  `BRCS_ASSERT_NOW(a_len_nonzero, out_valid_o, segment_length_o != '0, "segment of zero length")

  `BRCS_ASSERT_NOW(a_stop_is_last, out_valid_o && stopped_at_disk_end_o, last_o, "disk-end flag on a segment that is not last")

  // A whole chunk always starts at its first byte.
  `BRCS_ASSERT_NOW(a_full_chunk_aligned, out_valid_o && !partial_chunk_o, chunk_offset_o == '0, "full-chunk segment with nonzero offset")

endmodule

bind byte_range_chunk_splitter_unit brcs_chk u_brcs_chk (.*);
`default_nettype wire
